### rtl/assert_macros.svh
// Assertion macros included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/sld_pkg.sv
// Shared types and constants for the disk head scheduler.
package sld_pkg;
    localparam int QueueDepth = 32;
    localparam int TrackBits  = 16;
    localparam int CountBits  = $clog2(QueueDepth + 1);
    localparam int IdxBits    = $clog2(QueueDepth);
    localparam int MoveBits   = 22;
    localparam logic [MoveBits-1:0] MoveMax = {MoveBits{1'b1}};

    localparam logic [1:0] ModeScan  = 2'd0;
    localparam logic [1:0] ModeCscan = 2'd1;
    localparam logic [1:0] ModeLook  = 2'd2;
    localparam logic [1:0] ModeClook = 2'd3;

    localparam logic CfgIdxMode   = 1'b0;
    localparam logic CfgIdxTracks = 1'b1;

    localparam logic OpSetHead = 1'b0;
    localparam logic OpRequest = 1'b1;

    // Entry passed from front end to back end through the queue.
    typedef struct packed {
        logic                 op;
        logic [TrackBits-1:0] track;
        logic                 up;
        logic                 last;
    } cmd_t;
endpackage

### rtl/sld_front.sv
// Front end: accepts items and holds them in a two-entry queue.
module sld_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sld_pkg::cmd_t  in_cmd,
    output logic           q_valid,
    input  logic           q_ready,
    output sld_pkg::cmd_t  q_cmd
);
    sld_pkg::cmd_t ent_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = ent_reg[rd_reg];

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Store incoming item
    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_reg] <= in_cmd;
    end
endmodule

### rtl/sld_back.sv
// Back end: sorted insertion of requests and sweep of the service order.
module sld_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    scan_mode,
    input  logic [16:0]                   disk_tracks,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  sld_pkg::cmd_t                 q_cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sld_pkg::TrackBits-1:0] out_track,
    output logic [sld_pkg::MoveBits-1:0]  out_move,
    output logic                          out_dir,
    output logic                          out_last
);
    localparam int TB = sld_pkg::TrackBits;
    localparam int PB = sld_pkg::TrackBits + 1;
    localparam int CB = sld_pkg::CountBits;
    localparam int IB = sld_pkg::IdxBits;
    localparam int MB = sld_pkg::MoveBits;
    localparam int QD = sld_pkg::QueueDepth;

    typedef enum logic [2:0] {
        S_ACCEPT, S_INSERT, S_SPLIT, S_PASS1, S_TRAVEL, S_PASS2, S_EMIT
    } state_t;

    // Sorted list kept in registers; insertion shifts in parallel.
    logic [TB-1:0] srt_reg [QD];
    logic [CB-1:0] cnt_reg;
    logic [TB-1:0] head_reg;
    logic          up_reg;
    state_t        st_reg;
    state_t        ret_reg;
    logic [TB-1:0] new_reg;
    logic          sched_reg;
    logic [CB-1:0] split_reg;
    logic [CB-1:0] idx_reg;
    logic [CB-1:0] left_reg;
    logic          pass2_reg;
    logic [1:0]    tstep_reg;
    logic [PB-1:0] pos_reg;
    logic [MB-1:0] mov_reg;
    logic          dir_reg;
    logic [TB-1:0] o_trk_reg;
    logic [MB-1:0] o_mov_reg;
    logic          o_dir_reg;
    logic          o_last_reg;
    logic          o_val_reg;

    logic [PB-1:0] end_trk;
    logic          circ;
    logic          ends;
    logic [TB-1:0] cur_trk;
    logic [PB-1:0] dst;
    logic [PB-1:0] gap;
    logic [MB:0]   sum;
    logic [MB-1:0] mov_sat;
    logic [PB-1:0] end_a;
    logic [PB-1:0] end_b;
    logic          has_p2;

    assign circ    = scan_mode[0];
    assign ends    = (scan_mode == sld_pkg::ModeScan) || (scan_mode == sld_pkg::ModeCscan);
    assign end_trk = (disk_tracks == 17'd0) ? '0 : PB'(disk_tracks - 17'd1);
    assign end_a   = up_reg ? end_trk : '0;
    assign end_b   = up_reg ? '0 : end_trk;
    assign cur_trk = srt_reg[idx_reg[IB-1:0]];
    assign has_p2  = up_reg ? (split_reg != '0) : (split_reg != cnt_reg);
    assign q_ready = (st_reg == S_ACCEPT);
    assign out_valid = o_val_reg;
    assign out_track = o_trk_reg;
    assign out_move  = o_mov_reg;
    assign out_dir   = o_dir_reg;
    assign out_last  = o_last_reg;

    // Destination of the current head move and saturating distance sum
    always_comb
    begin
        if (st_reg == S_TRAVEL)
            dst = (tstep_reg == 2'd0) ? end_a : end_b;
        else
            dst = {1'b0, cur_trk};
        gap     = (pos_reg > dst) ? (pos_reg - dst) : (dst - pos_reg);
        sum     = {1'b0, mov_reg} + (MB+1)'(gap);
        mov_sat = sum[MB] ? sld_pkg::MoveMax : sum[MB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_ACCEPT;
            ret_reg    <= S_PASS1;
            cnt_reg    <= '0;
            head_reg   <= '0;
            up_reg     <= 1'b1;
            o_val_reg  <= 1'b0;
            sched_reg  <= 1'b0;
            new_reg    <= '0;
            split_reg  <= '0;
            idx_reg    <= '0;
            left_reg   <= '0;
            pass2_reg  <= 1'b0;
            tstep_reg  <= '0;
            pos_reg    <= '0;
            mov_reg    <= '0;
            dir_reg    <= 1'b0;
            o_trk_reg  <= '0;
            o_mov_reg  <= '0;
            o_dir_reg  <= 1'b0;
            o_last_reg <= 1'b0;
        end
        else
        begin
            if (o_val_reg && out_ready)
                o_val_reg <= 1'b0;
            case (st_reg)
                S_ACCEPT:
                begin
                    if (q_valid)
                    begin
                        if (q_cmd.op == sld_pkg::OpSetHead)
                        begin
                            head_reg <= q_cmd.track;
                            up_reg   <= q_cmd.up;
                        end
                        else
                        begin
                            new_reg   <= q_cmd.track;
                            sched_reg <= q_cmd.last;
                            st_reg    <= S_INSERT;
                        end
                    end
                end
                S_INSERT:
                begin
                    // Insert the new track into the sorted list, drop if full
                    if (cnt_reg != CB'(QD))
                    begin
                        for (int k = QD - 1; k >= 0; k--)
                        begin
                            if (CB'(k) < cnt_reg && srt_reg[k] > new_reg)
                                srt_reg[(k + 1) % QD] <= srt_reg[k];
                            if ((CB'(k) == cnt_reg || srt_reg[k] > new_reg)
                                && (k == 0 || CB'(k) > cnt_reg ||
                                    !(srt_reg[(k + QD - 1) % QD] > new_reg)))
                            begin
                                if (CB'(k) <= cnt_reg)
                                    srt_reg[k] <= new_reg;
                            end
                        end
                        cnt_reg <= cnt_reg + CB'(1);
                    end
                    split_reg <= '0;
                    st_reg    <= sched_reg ? S_SPLIT : S_ACCEPT;
                end
                S_SPLIT:
                begin
                    // Walk to the first track at or above the head
                    if (split_reg < cnt_reg &&
                        srt_reg[split_reg[IB-1:0]] < head_reg)
                        split_reg <= split_reg + CB'(1);
                    else
                    begin
                        pos_reg   <= {1'b0, head_reg};
                        mov_reg   <= '0;
                        pass2_reg <= 1'b0;
                        tstep_reg <= '0;
                        dir_reg   <= circ ? up_reg : ~up_reg;
                        if (up_reg)
                        begin
                            idx_reg  <= split_reg;
                            left_reg <= cnt_reg - split_reg;
                        end
                        else
                        begin
                            idx_reg  <= split_reg - CB'(1);
                            left_reg <= split_reg;
                        end
                        st_reg <= S_PASS1;
                    end
                end
                S_PASS1, S_PASS2:
                begin
                    if (left_reg == '0)
                    begin
                        if (!pass2_reg && has_p2)
                        begin
                            pass2_reg <= 1'b1;
                            if (up_reg)
                            begin
                                idx_reg  <= circ ? '0 : split_reg - CB'(1);
                                left_reg <= split_reg;
                            end
                            else
                            begin
                                idx_reg  <= circ ? cnt_reg - CB'(1) : split_reg;
                                left_reg <= cnt_reg - split_reg;
                            end
                            tstep_reg <= '0;
                            st_reg    <= ends ? S_TRAVEL : S_PASS2;
                        end
                        else
                        begin
                            // Batch done: head and direction carry over, the sorted list is cleared
                            if (cnt_reg != '0)
                                head_reg <= pos_reg[TB-1:0];
                            up_reg  <= dir_reg;
                            cnt_reg <= '0;
                            st_reg  <= S_ACCEPT;
                        end
                    end
                    else if (!o_val_reg)
                    begin
                        o_trk_reg <= cur_trk;
                        o_mov_reg <= mov_sat;
                        mov_reg   <= mov_sat;
                        pos_reg   <= {1'b0, cur_trk};
                        left_reg  <= left_reg - CB'(1);
                        // Ascend when sweeping up; the way back of a non-circular reversal goes the other way
                        if (up_reg ^ ((st_reg == S_PASS2) && !circ))
                            idx_reg <= idx_reg + CB'(1);
                        else
                            idx_reg <= idx_reg - CB'(1);
                        ret_reg <= st_reg;
                        st_reg  <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    o_last_reg <= (left_reg == '0) && (pass2_reg || !has_p2);
                    o_dir_reg  <= ((left_reg == '0) && (pass2_reg || !has_p2)) ? dir_reg : 1'b0;
                    o_val_reg  <= 1'b1;
                    st_reg     <= ret_reg;
                end
                S_TRAVEL:
                begin
                    // End run, and for circular modes the jump across
                    mov_reg <= mov_sat;
                    pos_reg <= dst;
                    if (circ && tstep_reg == 2'd0)
                        tstep_reg <= 2'd1;
                    else
                        st_reg <= S_PASS2;
                end
                default:
                    st_reg <= S_ACCEPT;
            endcase
        end
    end
endmodule

### rtl/scan_look_disk_scheduler_core.sv
// Top level of the SCAN / C-SCAN / LOOK / C-LOOK disk head scheduler.
// Set-head items load head and direction; request items are inserted into
// a sorted list (queue pop, then a parallel shift insert). The request
// marked tlast schedules the batch: a split search, then for each served
// track the steps serve, present and drain the output register, plus end
// travel in SCAN and C-SCAN (and the jump across in C-SCAN) and a step to
// close the batch. Results are one item per served track, tlast on the
// last. Configuration writes are for idle periods only.
module scan_look_disk_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [0] operation, [16:1] track, [17] toward_larger
    input  logic        s_axis_tlast,   // batch_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] served_track, [37:16] movement_so_far,
                                        // [38] final_toward_larger
    output logic        m_axis_tlast    // last_of_batch
);
    logic [1:0]    mode_reg;
    logic [16:0]   tracks_reg;
    sld_pkg::cmd_t in_cmd;
    sld_pkg::cmd_t q_cmd;
    logic          q_valid;
    logic          q_ready;
    logic [15:0]   o_trk;
    logic [21:0]   o_mov;
    logic          o_dir;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sld_pkg::ModeScan;
            tracks_reg <= 17'h10000;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == sld_pkg::CfgIdxMode)
                mode_reg <= cfg_data[1:0];
            else
                tracks_reg <= cfg_data;
        end
    end

    assign in_cmd.op    = s_axis_tdata[0];
    assign in_cmd.track = s_axis_tdata[16:1];
    assign in_cmd.up    = s_axis_tdata[17];
    assign in_cmd.last  = s_axis_tlast;

    sld_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    sld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .scan_mode   (mode_reg),
        .disk_tracks (tracks_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_cmd       (q_cmd),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_track   (o_trk),
        .out_move    (o_mov),
        .out_dir     (o_dir),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, o_dir, o_mov, o_trk};
endmodule

### rtl/sld_checker.sv
// Port-level checker for the disk head scheduler, bound to the top level.
`include "assert_macros.svh"
module sld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    `ASSERT_IMP(a_dir_only_last, clk, rst_n, m_axis_tvalid && !m_axis_tlast, !m_axis_tdata[38], "direction set on a non-final result")
    `ASSERT_IMP(a_pad_zero, clk, rst_n, m_axis_tvalid, !m_axis_tdata[39], "padding bit set")
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `ASSERT_NEXT(a_move_grows, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid || m_axis_tdata[37:16] >= $past(m_axis_tdata[37:16]), "movement decreased within batch")
endmodule

bind scan_look_disk_scheduler_core sld_checker u_sld_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
